@@ hw/rtl/mpsm_pkg.sv @@
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants of the streaming Morris-Pratt matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  // Default pattern capacity in bytes.
  localparam int MaxPatternDef = 16;

  // Width of the line position counter and of a reported position.
  localparam int PosWidth = 16;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEXT   = 2'd2,
    REQ_EOL    = 2'd3
  } req_e;

  // Classified command handed from the front end to the engine.
  typedef struct packed {
    req_e       kind;
    logic [7:0] data;
  } cmd_t;

endpackage

@@ hw/rtl/mpsm_front.sv @@
// ----------------------------------------------------------------------------
// mpsm_front
// Accepts request items, classifies them and holds them in a two-entry
// command queue so that the input side stalls independently of the engine.
// ----------------------------------------------------------------------------
module mpsm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         data_byte_i,
  output logic               cmd_valid_o,
  output mpsm_pkg::cmd_t     cmd_o,
  input  logic               cmd_ready_i
);
  import mpsm_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  cmd_t       cmd_in;

  assign cmd_in.kind = req_e'(req_type_i);
  assign cmd_in.data = data_byte_i;

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

@@ hw/rtl/mpsm_engine.sv @@
// ----------------------------------------------------------------------------
// mpsm_engine
// Executes queued commands: builds the failure table on append and walks
// the failure chain on text bytes, one step per cycle through registered
// pattern and failure memories.
// ----------------------------------------------------------------------------
module mpsm_engine #(
  parameter int MAX_PATTERN = mpsm_pkg::MaxPatternDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  mpsm_pkg::cmd_t                cmd_i,
  output logic                          cmd_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mpsm_pkg::PosWidth-1:0] match_pos_o
);
  import mpsm_pkg::*;

  localparam int IW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [IW-1:0] MaxLen = IW'(MAX_PATTERN);
  localparam logic [PosWidth-1:0] PosMax = '1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_AINIT = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_MATCH = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [IW-1:0]       q_q, q_d;
  logic [IW-1:0]       plen_q, plen_d;
  logic [IW-1:0]       matched_q, matched_d;
  logic [PosWidth-1:0] line_q, line_d;
  logic [7:0]          byte_q, byte_d;
  logic                append_q, append_d;
  logic                out_valid_q, out_valid_d;
  logic [PosWidth-1:0] pos_q, pos_d;

  logic [7:0]          pat_mem [MAX_PATTERN];
  logic [IW-1:0]       fail_mem [MAX_PATTERN + 1];
  logic [7:0]          pat_rd_q;
  logic [IW-1:0]       fail_rd_q;

  logic                pat_we;
  logic                fail_we;
  logic [IW-1:0]       fail_wa;
  logic [IW-1:0]       fail_wd;
  logic                fail_ra_plen;
  logic [IW-1:0]       fail_ra;
  logic [AW-1:0]       pat_ra;

  logic                hit, at_root, walk_done, out_free;
  logic [IW-1:0]       walk_res;

  assign hit       = (pat_rd_q == byte_q);
  assign at_root   = (q_q == '0);
  assign walk_done = hit || at_root;
  assign walk_res  = hit ? (q_q + 1'b1) : '0;
  assign out_free  = !out_valid_q || out_ready_i;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign match_pos_o = pos_q;

  always_comb begin
    state_d      = state_q;
    q_d          = q_q;
    plen_d       = plen_q;
    matched_d    = matched_q;
    line_d       = line_q;
    byte_d       = byte_q;
    append_d     = append_q;
    out_valid_d  = out_valid_q;
    pos_d        = pos_q;
    pat_we       = 1'b0;
    fail_we      = 1'b0;
    fail_wa      = plen_q + 1'b1;
    fail_wd      = walk_res;
    fail_ra_plen = 1'b0;

    // Drain the output register.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          byte_d = cmd_i.data;
          unique case (cmd_i.kind)
            REQ_CLEAR: begin
              plen_d    = '0;
              matched_d = '0;
            end
            REQ_APPEND: begin
              if (plen_q != MaxLen) begin
                pat_we = 1'b1;
                if (plen_q == '0) begin
                  // Single-byte pattern has an empty border.
                  fail_we = 1'b1;
                  fail_wa = IW'(1);
                  fail_wd = '0;
                  plen_d  = IW'(1);
                end else begin
                  fail_ra_plen = 1'b1;
                  append_d     = 1'b1;
                  state_d      = S_AINIT;
                end
              end
            end
            REQ_TEXT: begin
              if (line_q != PosMax) begin
                line_d = line_q + 1'b1;
              end
              if (plen_q != '0) begin
                q_d      = matched_q;
                append_d = 1'b0;
                state_d  = S_WALK;
              end
            end
            REQ_EOL: begin
              matched_d = '0;
              line_d    = '0;
            end
            default: ;
          endcase
        end
      end
      S_AINIT: begin
        q_d     = fail_rd_q;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (!walk_done) begin
          q_d = fail_rd_q;
        end else if (append_q) begin
          fail_we = 1'b1;
          plen_d  = plen_q + 1'b1;
          state_d = S_IDLE;
        end else if (walk_res == plen_q) begin
          fail_ra_plen = 1'b1;
          state_d      = S_MATCH;
        end else begin
          matched_d = walk_res;
          state_d   = S_IDLE;
        end
      end
      S_MATCH: begin
        fail_ra_plen = 1'b1;
        if (out_free) begin
          out_valid_d = 1'b1;
          pos_d       = line_q - PosWidth'(plen_q) + 1'b1;
          matched_d   = fail_rd_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign fail_ra = fail_ra_plen ? plen_q : q_d;
  assign pat_ra  = q_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      q_q         <= '0;
      plen_q      <= '0;
      matched_q   <= '0;
      line_q      <= '0;
      append_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      q_q         <= q_d;
      plen_q      <= plen_d;
      matched_q   <= matched_d;
      line_q      <= line_d;
      append_q    <= append_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    pos_q  <= pos_d;
  end

  // Pattern memory: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[plen_q[AW-1:0]] <= cmd_i.data;
    end
    pat_rd_q <= pat_mem[pat_ra];
  end

  // Failure memory: entry zero is never stored, the root is handled in logic.
  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_wa] <= fail_wd;
    end
    fail_rd_q <= fail_mem[fail_ra];
  end

  a_plen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= MaxLen)
    else $error("pattern length beyond capacity");

  a_matched_below_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (plen_q == '0) || (matched_q < plen_q))
    else $error("matched length not below pattern length");

  a_walk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (q_q < plen_q))
    else $error("failure walk outside written pattern");

  a_match_needs_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MATCH) |-> !append_q && (plen_q != '0))
    else $error("match state reached without a text walk");

endmodule

@@ hw/rtl/morris_pratt_string_match.sv @@
// ----------------------------------------------------------------------------
// morris_pratt_string_match
// Streaming Morris-Pratt matcher: loads a pattern byte by byte and reports
// the 1-based in-line start position of every (overlapping) match.
// ----------------------------------------------------------------------------
//
//   channel | signals                                  | moves
//   --------+------------------------------------------+------------------------
//   in      | in_valid_i, in_ready_o,                  | one request item
//           | req_type_i, data_byte_i                  | (clear/append/text/eol)
//   out     | out_valid_o, out_ready_i, match_pos_o    | one match position item
//
// Steps: clear, end of line and a text byte on an empty pattern are done in the
//   idle state; any other text byte goes on to the walk state, one step per
//   failure-chain link, then to the match state when it completes a match; the
//   first append is done in the idle state, later ones pass through the init
//   and walk states. The engine has a single walk unit, one chain step per cycle
//   through the registered pattern and failure memory reads.
// Reset: rst_ni clears the pattern length, match state and line position.
// Stalls: a two-entry command queue takes items while the engine walks;
//   a pending result waits in the output register without blocking input
//   until the next match completes, which holds the engine until it drains.
//
module morris_pratt_string_match #(
  parameter int MAX_PATTERN = mpsm_pkg::MaxPatternDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mpsm_pkg::PosWidth-1:0] match_pos_o
);
  import mpsm_pkg::*;

  // Command handoff between front end and engine.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Accept and classify items; buffer them so input keeps flowing.
  mpsm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Build the failure table and walk the failure chain.
  mpsm_engine #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .match_pos_o (match_pos_o)
  );

endmodule

@@ bench/mpsm_checker.sv @@
// ----------------------------------------------------------------------------
// mpsm_checker
// Watches both channels of the matcher, keeps its own copy of the pattern,
// border table and line position, and compares every match position that
// leaves the block against the oldest predicted one.
// ----------------------------------------------------------------------------
module mpsm_checker #(
  parameter int MAX_PATTERN = mpsm_pkg::MaxPatternDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    req_type_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [mpsm_pkg::PosWidth-1:0] match_pos_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  import mpsm_pkg::*;

  logic [7:0]          pat_bytes [MAX_PATTERN];
  int                  border [MAX_PATTERN+1];
  int                  pat_len;
  int                  run_len;
  logic [PosWidth-1:0] line_pos;
  logic [PosWidth-1:0] due_pos [$];
  logic [PosWidth-1:0] want;

  // Add one pattern byte and the border length of the longer prefix.
  function automatic void extend_pattern(input logic [7:0] b);
    int j;
    if (pat_len >= MAX_PATTERN) return;
    pat_bytes[pat_len] = b;
    j = border[pat_len];
    while (j >= 0 && pat_bytes[j] != b) j = border[j];
    border[pat_len+1] = j + 1;
    pat_len++;
  endfunction

  // Advance the line position and the match state by one text byte.
  function automatic void scan_text_byte(input logic [7:0] b);
    int q;
    if (line_pos != '1) line_pos++;
    if (pat_len == 0) return;
    q = run_len;
    while (q >= 0 && pat_bytes[q] != b) q = border[q];
    q++;
    if (q == pat_len) begin
      due_pos.push_back(PosWidth'(int'(line_pos) - pat_len + 1));
      run_len = border[pat_len];
    end else begin
      run_len = q;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len      = 0;
      run_len      = 0;
      line_pos     = '0;
      border[0]    = -1;
      due_pos.delete();
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      // Retire the older result first: it can never belong to this edge's item.
      if (out_valid_i && out_ready_i) begin
        if (due_pos.size() == 0) begin
          $error("match_pos: expected none, actual %0d", match_pos_i);
          fail_count_o++;
        end else begin
          want = due_pos.pop_front();
          checked_o++;
          if (match_pos_i !== want) begin
            $error("match_pos: expected %0d, actual %0d", want, match_pos_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (req_e'(req_type_i))
          REQ_CLEAR: begin
            pat_len = 0;
            run_len = 0;
          end
          REQ_APPEND: extend_pattern(data_byte_i);
          REQ_TEXT:   scan_text_byte(data_byte_i);
          default: begin
            run_len  = 0;
            line_pos = '0;
          end
        endcase
      end
    end
    pending_o = due_pos.size();
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives request items into the Morris-Pratt matcher with random gaps and
// output stalls: a short directed sequence and random pattern/line sequences.
// ----------------------------------------------------------------------------
module tb;

  import mpsm_pkg::*;

  localparam int Cap        = MaxPatternDef;
  localparam int RandTarget = 1250;
  localparam int StallLimit = 1000;   // cycles with no item moving on either side
  localparam int DrainWait  = 40;     // long enough for the longest text byte with a full chain walk and a match

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          req_type = REQ_CLEAR;
  logic [7:0]          data_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PosWidth-1:0] match_pos;

  int fail_count;
  int pending;
  int checked;

  // Stimulus bookkeeping: what the block should hold as pattern right now.
  logic [7:0] loaded [Cap];
  int         loaded_len = 0;
  int         sent_items = 0;
  int         useful_items = 0;
  int         idle_cycles;
  bit         calm = 1'b0;   // set: neither side idles

  always #10 clk_i = ~clk_i;

  morris_pratt_string_match dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .match_pos_o (match_pos)
  );

  mpsm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .req_type_i   (req_type),
    .data_byte_i  (data_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .match_pos_i  (match_pos),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Draw a per-item wait; calm stretches keep both sides busy back to back.
  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Offer one item: idle for the drawn gap, raise valid with the payload at a
  // falling edge, then hold it until a rising edge sees ready.
  task automatic push_item(input req_e kind, input logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid  <= 1'b1;
    req_type  <= kind;
    data_byte <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_items++;
    // Track the loaded pattern; an append past capacity changes nothing.
    case (kind)
      REQ_CLEAR: loaded_len = 0;
      REQ_APPEND: begin
        if (loaded_len < Cap) begin
          loaded[loaded_len] = b;
          loaded_len++;
          useful_items++;
        end
      end
      default: useful_items++;
    endcase
    if (kind == REQ_CLEAR) useful_items++;
  endtask

  // Receiver: stall for a fresh draw before each result, then wait for it.
  initial begin
    @(posedge rst_ni);
    forever begin
      int w;
      w = draw_wait();
      if (w > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (w - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  // Count cycles in which no item moves on either channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run once the block has hung for too long.
  initial begin
    @(posedge rst_ni);
    while (idle_cycles < StallLimit) @(negedge clk_i);
    $display("Timeout: no item moved for %0d cycles, %0d positions pending",
             StallLimit, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // Hit empty pattern, extreme bytes, overlap, end of line, and a clear
  // in mid-line that must keep the line position.
  task automatic run_directed();
    push_item(REQ_CLEAR, 8'hFF);
    push_item(REQ_TEXT, 8'h00);     // empty pattern: position only
    push_item(REQ_EOL, 8'hFF);
    push_item(REQ_APPEND, 8'h00);
    push_item(REQ_APPEND, 8'hFF);
    push_item(REQ_APPEND, 8'h00);
    push_item(REQ_TEXT, 8'h00);
    push_item(REQ_TEXT, 8'hFF);
    push_item(REQ_TEXT, 8'h00);     // match at 1
    push_item(REQ_TEXT, 8'hFF);
    push_item(REQ_TEXT, 8'h00);     // overlapping match at 3
    push_item(REQ_EOL, 8'h00);
    push_item(REQ_TEXT, 8'hFF);
    push_item(REQ_TEXT, 8'h00);
    push_item(REQ_TEXT, 8'hFF);
    push_item(REQ_TEXT, 8'h00);     // match at 2
    push_item(REQ_CLEAR, 8'h00);
    push_item(REQ_APPEND, 8'h00);
    push_item(REQ_TEXT, 8'h00);     // one-byte pattern, match at 5
    push_item(REQ_TEXT, 8'h01);
    push_item(REQ_EOL, 8'h00);
  endtask

  // Mostly well-formed sequences over a small alphabet, so that matches and
  // failure-chain walks happen often; the rest is random noise.
  task automatic run_random();
    logic [7:0] alpha [3];
    int         n_alpha;
    int         len;
    int         start;
    logic [7:0] b;
    start   = useful_items;
    n_alpha = 2;
    foreach (alpha[i]) alpha[i] = 8'($urandom);
    while (useful_items - start < RandTarget) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 8)) push_item(req_e'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        // Load a fresh pattern most of the time; some run well past capacity.
        if (loaded_len == 0 || $urandom_range(0, 3) != 0) begin
          n_alpha = $urandom_range(1, 3);
          foreach (alpha[i]) alpha[i] = 8'($urandom);
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, Cap + 4)
                                            : $urandom_range(1, 5);
          push_item(REQ_CLEAR, 8'($urandom));
          for (int i = 0; i < len; i++) begin
            push_item(REQ_APPEND, alpha[$urandom_range(0, n_alpha - 1)]);
          end
        end
        // Build a line from pattern copies, alphabet runs and stray bytes.
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0, 1: begin
              len = loaded_len;
              for (int i = 0; i < len; i++) push_item(REQ_TEXT, loaded[i]);
            end
            2: begin
              repeat ($urandom_range(1, 4)) begin
                b = alpha[$urandom_range(0, n_alpha - 1)];
                push_item(REQ_TEXT, b);
              end
            end
            default: push_item(REQ_TEXT, 8'($urandom));
          endcase
        end
        if ($urandom_range(0, 4) != 0) push_item(REQ_EOL, 8'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random();

    // Drop valid, drain every predicted position, then let stray results show.
    @(negedge clk_i);
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainWait) @(negedge clk_i);

    $display("Sent %0d request items; checked %0d match positions.",
             sent_items, checked);
    $display("Patterns of 1 to %0d bytes, appends past capacity, clears and line ends mixed in.",
             Cap);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/mpsm_pkg.sv
hw/rtl/mpsm_front.sv
hw/rtl/mpsm_engine.sv
hw/rtl/morris_pratt_string_match.sv
bench/mpsm_checker.sv
bench/tb.sv
